// ===== rtl/rhht_pkg.sv =====
// Shared types and constants for the Robin Hood hash table.
`default_nettype none
package rhht_pkg;
	localparam int TABLE_SLOTS = 256;
	localparam int NAME_BITS   = 64;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int COUNT_W     = SLOT_W + 1;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	// classified job passed from front to back
	typedef struct packed {
		cmd_t                 cmd;
		slot_t                home;
		logic [NAME_BITS-1:0] name;
		logic [63:0]          ref_h;
		logic [31:0]          len;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_CHECK,
		BK_DONE
	} bk_state_t;
endpackage
`default_nettype wire

// ===== rtl/rhht_front.sv =====
// Front end: takes input transactions, classifies them and queues jobs.
`default_nettype none
module rhht_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                command,
	input  wire logic [31:0]         hash_key,
	input  wire logic [63:0]         name_key,
	input  wire logic [63:0]         content_ref,
	input  wire logic [31:0]         content_len,
	output logic                     job_valid,
	input  wire logic                job_take,
	output rhht_pkg::job_t           job
);
	import rhht_pkg::*;

	job_t   q_mem_q [QUEUE_DEPTH];
	logic   wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic   push, pop;

	assign in_stall  = (fill_q == 2'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign job_valid = (fill_q != 2'd0);
	assign pop       = job_valid && job_take;
	assign job       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q].cmd   <= cmd_t'(command);
			q_mem_q[wr_ptr_q].home  <= hash_key[SLOT_W-1:0];
			q_mem_q[wr_ptr_q].name  <= name_key[NAME_BITS-1:0];
			q_mem_q[wr_ptr_q].ref_h <= content_ref;
			q_mem_q[wr_ptr_q].len   <= content_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/rhht_back.sv =====
// Back end: walks the probe sequence through the slot memory.
`default_nettype none
module rhht_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                job_valid,
	output logic                     job_take,
	input  wire rhht_pkg::job_t      job,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               status,
	output logic [63:0]              found_ref,
	output logic [31:0]              found_len
);
	import rhht_pkg::*;

	localparam int ENT_W = NAME_BITS + SLOT_W + 64 + 32;

	logic [ENT_W-1:0] mem [TABLE_SLOTS];
	logic [ENT_W-1:0] rd_data_q;
	logic [TABLE_SLOTS-1:0] valid_q;

	bk_state_t state_q, state_d;
	job_t      cur_q;
	slot_t     dist_q, loc_q;
	logic [COUNT_W-1:0] count_q;
	slot_t     maxd_q;
	logic      slot_vld_q;

	status_t   res_status_q;
	logic [63:0] res_ref_q;
	logic [31:0] res_len_q;

	logic [NAME_BITS-1:0] r_name;
	slot_t r_home, resident, loc_next;
	logic [63:0] r_ref;
	logic [31:0] r_len;
	logic        wr_en;
	logic [ENT_W-1:0] wr_data;
	logic        full;

	assign {r_name, r_home, r_ref, r_len} = rd_data_q;
	assign resident = loc_q - r_home;
	assign loc_next = loc_q + slot_t'(1);
	assign full     = (count_q == COUNT_W'(TABLE_SLOTS));
	assign wr_data  = {cur_q.name, cur_q.home, cur_q.ref_h, cur_q.len};

	// write on empty slot or displacement swap during an insert
	always_comb begin
		wr_en = 1'b0;
		if (state_q == BK_CHECK && cur_q.cmd == CMD_INSERT)
			wr_en = !slot_vld_q || (dist_q > resident);
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[loc_q] <= wr_data;
		rd_data_q <= mem[loc_q];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					// a refused insert goes straight to the result
					if (job.cmd == CMD_INSERT && full) state_d = BK_DONE;
					else state_d = BK_READ;
				end
			end
			BK_READ:  state_d = BK_CHECK;
			BK_CHECK: begin
				if (cur_q.cmd == CMD_INSERT) begin
					if (!slot_vld_q) state_d = BK_DONE;
					else state_d = BK_READ;
				end else begin
					if (!slot_vld_q || r_name == cur_q.name || dist_q == maxd_q)
						state_d = BK_DONE;
					else state_d = BK_READ;
				end
			end
			BK_DONE:  if (!out_stall) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_take  = (state_q == BK_IDLE) && job_valid;
		out_valid = (state_q == BK_DONE);
	end

	assign status    = res_status_q;
	assign found_ref = res_ref_q;
	assign found_len = res_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			cur_q        <= '0;
			valid_q      <= '0;
			count_q      <= '0;
			maxd_q       <= '0;
			dist_q       <= '0;
			loc_q        <= '0;
			slot_vld_q   <= 1'b0;
			res_status_q <= ST_INSERTED;
			res_ref_q    <= '0;
			res_len_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				BK_IDLE: begin
					if (job_valid) begin
						cur_q      <= job;
						loc_q      <= job.home;
						dist_q     <= '0;
						slot_vld_q <= valid_q[job.home];
						res_ref_q  <= '0;
						res_len_q  <= '0;
						res_status_q <= (job.cmd == CMD_LOOKUP) ? ST_NOT_FOUND :
							(full ? ST_FULL : ST_INSERTED);
					end
				end
				BK_READ: ;
				BK_CHECK: begin
					if (cur_q.cmd == CMD_INSERT) begin
						if (!slot_vld_q) begin
							valid_q[loc_q] <= 1'b1;
							count_q <= count_q + COUNT_W'(1);
							if (dist_q > maxd_q) maxd_q <= dist_q;
						end else begin
							if (dist_q > resident) begin
								// swap: carry the evicted entry onward
								if (dist_q > maxd_q) maxd_q <= dist_q;
								cur_q.name  <= r_name;
								cur_q.home  <= r_home;
								cur_q.ref_h <= r_ref;
								cur_q.len   <= r_len;
								dist_q      <= resident + slot_t'(1);
							end else begin
								dist_q <= dist_q + slot_t'(1);
							end
							loc_q      <= loc_next;
							slot_vld_q <= valid_q[loc_next];
						end
					end else begin
						if (slot_vld_q && r_name == cur_q.name) begin
							res_status_q <= ST_FOUND;
							res_ref_q    <= r_ref;
							res_len_q    <= r_len;
						end else if (slot_vld_q && dist_q != maxd_q) begin
							dist_q     <= dist_q + slot_t'(1);
							loc_q      <= loc_next;
							slot_vld_q <= valid_q[loc_next];
						end
					end
				end
				BK_DONE: ;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/robin_hood_hash_table.sv =====
// Robin Hood hash table: front queue plus probing back end.
// Each job leaves the front queue, the back end reads and checks slot after slot, then holds
// the result until out_stall is low; a refused insert goes straight to the result.
// The back end takes no new job until the last result is taken, since the probe walk
// uses the single read/write port of the slot memory in the back end.
// Reset: arst_n clears all slot valid bits, entry count and max displacement at once.
`default_nettype none
module robin_hood_hash_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [31:0] hash_key,
	input  wire logic [63:0] name_key,
	input  wire logic [63:0] content_ref,
	input  wire logic [31:0] content_len,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [63:0]      found_ref,
	output logic [31:0]      found_len
);
	import rhht_pkg::*;

	job_t job;
	logic job_valid, job_take;

	rhht_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .hash_key, .name_key,
		.content_ref, .content_len, .job_valid, .job_take, .job
	);

	rhht_back u_back (
		.clk, .arst_n, .job_valid, .job_take, .job, .out_valid, .out_stall,
		.status, .found_ref, .found_len
	);
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the Robin Hood hash table: directed table, random mix, checks.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rhht_pkg::*;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] hash;
		logic [63:0] name;
		logic [63:0] ref_h;
		logic [31:0] len;
		bit          has_exp;
		status_t     exp_st;
	} stim_t;

	typedef struct {
		status_t     st;
		logic [63:0] ref_h;
		logic [31:0] len;
	} reply_t;

	localparam int WATCHDOG = 20000;

	logic clk, arst_n;
	logic in_valid, in_stall, command;
	logic [31:0] hash_key, content_len;
	logic [63:0] name_key, content_ref;
	logic out_valid, out_stall;
	logic [1:0] status;
	logic [63:0] found_ref;
	logic [31:0] found_len;

	robin_hood_hash_table u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .hash_key(hash_key), .name_key(name_key),
		.content_ref(content_ref), .content_len(content_len),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .found_ref(found_ref), .found_len(found_len)
	);

	// shadow table
	logic        tbl_valid [TABLE_SLOTS];
	logic [63:0] tbl_name  [TABLE_SLOTS];
	slot_t       tbl_home  [TABLE_SLOTS];
	logic [63:0] tbl_ref   [TABLE_SLOTS];
	logic [31:0] tbl_len   [TABLE_SLOTS];
	int          tbl_count;
	int          tbl_maxd;

	reply_t      pending_replies[$];
	logic [63:0] stored_names[$];
	logic [31:0] stored_hashes[$];
	int          errors = 0;
	int          table_errors;
	bit          calm;
	bit          hold_req;
	int          idle_cycles = 0;

	function automatic reply_t hash_table_step(stim_t s);
		reply_t r;
		slot_t  home, loc, th;
		logic [63:0] nm, rf, tn, tr;
		logic [31:0] ln, tl;
		int pdist, res, td;
		home = s.hash[SLOT_W-1:0];
		nm = s.name;
		rf = s.ref_h;
		ln = s.len;
		r.ref_h = '0;
		r.len = '0;
		if (s.cmd == CMD_INSERT) begin
			if (tbl_count >= TABLE_SLOTS) begin
				r.st = ST_FULL;
				return r;
			end
			r.st = ST_INSERTED;
			pdist = 0;
			for (int k = 0; k < TABLE_SLOTS; k++) begin
				loc = slot_t'(home + pdist);
				if (!tbl_valid[loc]) begin
					tbl_valid[loc] = 1'b1;
					tbl_name[loc] = nm;
					tbl_home[loc] = home;
					tbl_ref[loc] = rf;
					tbl_len[loc] = ln;
					if (pdist > tbl_maxd) tbl_maxd = pdist;
					tbl_count++;
					return r;
				end
				res = int'(slot_t'(loc - tbl_home[loc]));
				if (pdist > res) begin
					tn = tbl_name[loc]; th = tbl_home[loc];
					tr = tbl_ref[loc]; tl = tbl_len[loc];
					tbl_name[loc] = nm; tbl_home[loc] = home;
					tbl_ref[loc] = rf; tbl_len[loc] = ln;
					if (pdist > tbl_maxd) tbl_maxd = pdist;
					nm = tn; home = th; rf = tr; ln = tl;
					pdist = res;
				end
				pdist++;
			end
			return r;
		end
		r.st = ST_NOT_FOUND;
		for (td = 0; td <= tbl_maxd && td < TABLE_SLOTS; td++) begin
			loc = slot_t'(home + td);
			if (!tbl_valid[loc]) break;
			if (tbl_name[loc] == nm) begin
				r.st = ST_FOUND;
				r.ref_h = tbl_ref[loc];
				r.len = tbl_len[loc];
				break;
			end
		end
		return r;
	endfunction

	function automatic stim_t mk(cmd_t c, logic [31:0] h, logic [63:0] n,
			logic [63:0] rf, logic [31:0] l, int he, status_t es);
		stim_t s;
		s.cmd = c; s.hash = h; s.name = n; s.ref_h = rf; s.len = l;
		s.has_exp = (he != 0); s.exp_st = es;
		return s;
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	// receiver: random stall bursts plus one long hold-off
	initial begin
		int n;
		bit hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 7);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// result checking
	always @(posedge clk) begin
		reply_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %0d",
					$time, status);
				errors++;
			end else begin
				e = pending_replies.pop_front();
				if (status !== e.st || found_ref !== e.ref_h || found_len !== e.len) begin
					$display("%0t: mismatch: expected %0d/%h/%h, actual %0d/%h/%h",
						$time, e.st, e.ref_h, e.len, status, found_ref, found_len);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_transaction(stim_t s);
		reply_t r;
		in_valid <= 1'b1;
		command <= s.cmd;
		hash_key <= s.hash;
		name_key <= s.name;
		content_ref <= s.ref_h;
		content_len <= s.len;
		do @(posedge clk); while (in_stall);
		r = hash_table_step(s);
		if (s.has_exp && r.st != s.exp_st) begin
			$display("%0t: predictor disagrees with table: expected %0d, actual %0d",
				$time, s.exp_st, r.st);
			table_errors++;
		end
		if (s.cmd == CMD_INSERT && r.st == ST_INSERTED) begin
			stored_names.push_back(s.name);
			stored_hashes.push_back(s.hash);
		end
		pending_replies.push_back(r);
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic stim_t random_item();
		stim_t s;
		int k;
		s.has_exp = 1'b0;
		s.exp_st = ST_INSERTED;
		s.ref_h = rnd64();
		s.len = $urandom;
		s.hash = $urandom;
		s.name = rnd64();
		// clustered homes give long probe chains
		if ($urandom_range(0, 1)) s.hash[7:0] = 8'($urandom_range(0, 15));
		if ($urandom_range(0, 1)) begin
			s.cmd = CMD_INSERT;
			if (stored_names.size() != 0 && $urandom_range(0, 9) == 0) begin
				k = $urandom_range(0, stored_names.size() - 1);
				s.name = stored_names[k];
			end
		end else begin
			s.cmd = CMD_LOOKUP;
			if (stored_names.size() != 0 && $urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, stored_names.size() - 1);
				s.name = stored_names[k];
				s.hash = stored_hashes[k];
			end
		end
		return s;
	endfunction

	stim_t directed[$];

	initial begin
		stim_t s;
		table_errors = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		tbl_count = 0;
		tbl_maxd = 0;
		foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
		in_valid = 1'b0;
		command = 1'b0;
		hash_key = '0;
		name_key = '0;
		content_ref = '0;
		content_len = '0;

		// empty-table miss, extremes, home wrap, duplicate names, collisions
		directed.push_back(mk(CMD_LOOKUP, 32'h0, 64'h0, 64'h0, 32'h0, 1, ST_NOT_FOUND));
		directed.push_back(mk(CMD_INSERT, 32'hFFFFFFFF, '1, '1, '1, 1, ST_INSERTED));
		directed.push_back(mk(CMD_LOOKUP, 32'hFFFFFFFF, '1, 64'h0, 32'h0, 1, ST_FOUND));
		directed.push_back(mk(CMD_INSERT, 32'h000000FF, 64'h1, 64'h11, 32'h1, 1, ST_INSERTED));
		directed.push_back(mk(CMD_INSERT, 32'h0, 64'h0, 64'h0, 32'h0, 1, ST_INSERTED));
		directed.push_back(mk(CMD_INSERT, 32'h100, 64'h0, 64'h22, 32'h2, 1, ST_INSERTED));
		directed.push_back(mk(CMD_LOOKUP, 32'h0, 64'h0, '1, '1, 0, ST_FOUND));
		directed.push_back(mk(CMD_LOOKUP, 32'hFF, 64'h1, 64'h0, 32'h0, 0, ST_FOUND));
		directed.push_back(mk(CMD_INSERT, 32'h1, 64'h5, 64'h55, 32'h5, 1, ST_INSERTED));
		directed.push_back(mk(CMD_LOOKUP, 32'h1, 64'h5, 64'h0, 32'h0, 0, ST_FOUND));
		directed.push_back(mk(CMD_LOOKUP, 32'h1, 64'h6, 64'h0, 32'h0, 1, ST_NOT_FOUND));
		directed.push_back(mk(CMD_LOOKUP, 32'h80, 64'h5, 64'h0, 32'h0, 1, ST_NOT_FOUND));
		directed.push_back(mk(CMD_INSERT, 32'hAAAA5555, 64'hAAAAAAAA55555555,
			64'h5555AAAA5555AAAA, 32'hAAAA5555, 1, ST_INSERTED));
		directed.push_back(mk(CMD_LOOKUP, 32'hAAAA5555, 64'hAAAAAAAA55555555,
			64'h0, 32'h0, 0, ST_FOUND));

		@(posedge arst_n);
		@(negedge clk);
		foreach (directed[i]) send_transaction(directed[i]);
		drain();

		// random mix; the table fills during this phase so full refusals occur
		for (int i = 0; i < 700; i++) begin
			if (i == 200) hold_req = 1'b1;
			send_transaction(random_item());
		end
		// keep the table full and probe it
		for (int i = 0; i < 400; i++) begin
			s = random_item();
			if (i % 3 == 0) s.cmd = CMD_INSERT;
			send_transaction(s);
		end
		calm = 1'b1;
		for (int i = 0; i < 350; i++) send_transaction(random_item());
		in_valid <= 1'b0;

		fork
			while (pending_replies.size() != 0) @(negedge clk);
			begin
				repeat (200000) @(negedge clk);
				$display("CHECK FAILED");
				$finish;
			end
		join_any
		disable fork;
		repeat (600) @(negedge clk);
		if (errors == 0 && table_errors == 0 && pending_replies.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/rhht_pkg.sv
rtl/rhht_front.sv
rtl/rhht_back.sv
rtl/robin_hood_hash_table.sv
dv/tb_top.sv
